>>> design/eatrm_pkg.sv
// Package for the Euler-angle to rotation-matrix unit: widths, CORDIC arctangent
// table and fixed-point helpers. No dependencies.
`default_nettype none
package eatrm_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = COEF_BITS - 2;
  localparam int CORDIC_STEPS = 20;
  localparam int XW = 33;
  localparam int ZW = 32;
  localparam logic signed [XW-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [COEF_BITS:0] ONE = (COEF_BITS+1)'(1) <<< FRAC_BITS;

  typedef logic signed [COEF_BITS:0] coef_t;

  typedef enum logic [0:0] {
    ORDER_RPY = 1'b0,
    ORDER_YPR = 1'b1
  } order_t;

  typedef enum logic [0:0] {
    REG_ROTATION_ORDER = 1'b0
  } reg_idx_t;

  function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0: v = 32'sd536870912;
      5'd1: v = 32'sd316933406;
      5'd2: v = 32'sd167458907;
      5'd3: v = 32'sd85004756;
      5'd4: v = 32'sd42667331;
      5'd5: v = 32'sd21354465;
      5'd6: v = 32'sd10679838;
      5'd7: v = 32'sd5340245;
      5'd8: v = 32'sd2670163;
      5'd9: v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      default: v = '0;
    endcase
    return v;
  endfunction

  // product of two Q.14 values, rounded back to Q.14
  function automatic coef_t fmul(input coef_t a, input coef_t b);
    logic signed [2*COEF_BITS+1:0] p;
    p = a * b + (2*COEF_BITS+2)'(1 <<< (FRAC_BITS-1));
    return coef_t'(p >>> FRAC_BITS);
  endfunction

  function automatic coef_t clamp_one(input logic signed [COEF_BITS+1:0] v);
    coef_t r;
    if (v > (COEF_BITS+2)'(ONE)) r = ONE;
    else if (v < -(COEF_BITS+2)'(ONE)) r = -ONE;
    else r = coef_t'(v);
    return r;
  endfunction
endpackage
`default_nettype wire

>>> design/euler_angles_to_rotation_matrix_unit.sv
// Euler angles to rotation matrix: three CORDIC pipelines, then a product pipeline.
// CORDIC input register, rotation steps and fold, then product stages A-D; one request per cycle;
// busy is always low and out_valid strobes once per request. Synchronous active-low
// reset clears the valid pipeline and rotation_order. Depends on eatrm_pkg, eatrm_sincos.
`default_nettype none
module euler_angles_to_rotation_matrix_unit
  import eatrm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire logic signed [ANGLE_BITS-1:0] in_roll_angle,
  input  wire logic signed [ANGLE_BITS-1:0] in_pitch_angle,
  input  wire logic signed [ANGLE_BITS-1:0] in_yaw_angle,
  output logic      out_valid,
  output logic signed [COEF_BITS-1:0] out_m00, out_m01, out_m02,
  output logic signed [COEF_BITS-1:0] out_m10, out_m11, out_m12,
  output logic signed [COEF_BITS-1:0] out_m20, out_m21, out_m22,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int LAT = CORDIC_STEPS + 2 + 4;

  logic order_r;
  logic order_sel;
  assign pready = 1'b1;
  assign busy = 1'b0;
  assign order_sel = (paddr == 2'(REG_ROTATION_ORDER * 4));
  assign prdata = order_sel ? {31'd0, order_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= ORDER_RPY;
    else if (psel && penable && pwrite && order_sel) order_r <= pwdata[0];
  end

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LAT-2:0], start};
  end
  assign out_valid = vld_r[LAT-1];

  coef_t sr, cr, sp, cp, sy, cy;
  eatrm_sincos u_roll  (.clk(clk), .angle(in_roll_angle),  .sin_o(sr), .cos_o(cr));
  eatrm_sincos u_pitch (.clk(clk), .angle(in_pitch_angle), .sin_o(sp), .cos_o(cp));
  eatrm_sincos u_yaw   (.clk(clk), .angle(in_yaw_angle),   .sin_o(sy), .cos_o(cy));

  // stage A: pairwise products
  coef_t cpcy_r, cpsy_r, crsy_r, cysp_r, crcy_r, spsr_r, cpsr_r, srsy_r, crsp_r, cysr_r;
  coef_t cpcr_r, sp_a_r, sr_a_r, sy_a_r;
  always_ff @(posedge clk) begin
    cpcy_r <= fmul(cp, cy); cpsy_r <= fmul(cp, sy); crsy_r <= fmul(cr, sy);
    cysp_r <= fmul(cy, sp); crcy_r <= fmul(cr, cy); spsr_r <= fmul(sp, sr);
    cpsr_r <= fmul(cp, sr); srsy_r <= fmul(sr, sy); crsp_r <= fmul(cr, sp);
    cysr_r <= fmul(cy, sr); cpcr_r <= fmul(cp, cr);
    sp_a_r <= sp; sr_a_r <= sr; sy_a_r <= sy;
  end

  // stage B: triple products, carry the rest
  coef_t t_cyspsr_r, t_spsrsy_r, t_crcysp_r, t_crspsy_r;
  coef_t b_cpcy_r, b_cpsy_r, b_crsy_r, b_crcy_r, b_cpsr_r, b_srsy_r, b_cysr_r;
  coef_t b_cpcr_r, b_sp_r;
  always_ff @(posedge clk) begin
    t_cyspsr_r <= fmul(cysp_r, sr_a_r);
    t_spsrsy_r <= fmul(spsr_r, sy_a_r);
    t_crcysp_r <= fmul(crcy_r, sp_a_r);
    t_crspsy_r <= fmul(crsp_r, sy_a_r);
    b_cpcy_r <= cpcy_r; b_cpsy_r <= cpsy_r; b_crsy_r <= crsy_r; b_crcy_r <= crcy_r;
    b_cpsr_r <= cpsr_r; b_srsy_r <= srsy_r; b_cysr_r <= cysr_r; b_cpcr_r <= cpcr_r;
    b_sp_r <= sp_a_r;
  end

  // stage C: sums and differences with saturation per composition order
  localparam int SW = COEF_BITS + 2;
  coef_t m_r [9];
  function automatic logic signed [SW-1:0] ex(input coef_t v);
    return SW'(v);
  endfunction
  always_ff @(posedge clk) begin
    m_r[0] <= clamp_one(ex(b_cpcy_r));
    m_r[8] <= clamp_one(ex(b_cpcr_r));
    if (order_r == ORDER_RPY) begin
      m_r[1] <= clamp_one(-ex(b_cpsy_r));
      m_r[2] <= clamp_one(ex(b_sp_r));
      m_r[3] <= clamp_one(ex(b_crsy_r) + ex(t_cyspsr_r));
      m_r[4] <= clamp_one(ex(b_crcy_r) - ex(t_spsrsy_r));
      m_r[5] <= clamp_one(-ex(b_cpsr_r));
      m_r[6] <= clamp_one(ex(b_srsy_r) - ex(t_crcysp_r));
      m_r[7] <= clamp_one(ex(b_cysr_r) + ex(t_crspsy_r));
    end else begin
      m_r[1] <= clamp_one(ex(t_cyspsr_r) - ex(b_crsy_r));
      m_r[2] <= clamp_one(ex(b_srsy_r) + ex(t_crcysp_r));
      m_r[3] <= clamp_one(ex(b_cpsy_r));
      m_r[4] <= clamp_one(ex(b_crcy_r) + ex(t_spsrsy_r));
      m_r[5] <= clamp_one(ex(t_crspsy_r) - ex(b_cysr_r));
      m_r[6] <= clamp_one(-ex(b_sp_r));
      m_r[7] <= clamp_one(ex(b_cpsr_r));
    end
  end

  // stage D: output register
  always_ff @(posedge clk) begin
    out_m00 <= m_r[0][COEF_BITS-1:0]; out_m01 <= m_r[1][COEF_BITS-1:0];
    out_m02 <= m_r[2][COEF_BITS-1:0]; out_m10 <= m_r[3][COEF_BITS-1:0];
    out_m11 <= m_r[4][COEF_BITS-1:0]; out_m12 <= m_r[5][COEF_BITS-1:0];
    out_m20 <= m_r[6][COEF_BITS-1:0]; out_m21 <= m_r[7][COEF_BITS-1:0];
    out_m22 <= m_r[8][COEF_BITS-1:0];
  end
endmodule
`default_nettype wire

>>> design/eatrm_sincos.sv
// Pipelined CORDIC sine/cosine: one rotation step per stage, quadrant fold at the end.
// Depends on eatrm_pkg.
`default_nettype none
module eatrm_sincos
  import eatrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output coef_t                      sin_o,
  output coef_t                      cos_o
);
  logic signed [XW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS+1];
  logic [1:0]           q_r [CORDIC_STEPS+1];
  logic [31:0]          ph;

  assign ph = {angle, (32-ANGLE_BITS)'(0)};

  always_ff @(posedge clk) begin
    x_r[0] <= CORDIC_X0;
    y_r[0] <= '0;
    z_r[0] <= ZW'({2'b00, ph[29:0]});
    q_r[0] <= ph[31:30];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      q_r[i+1] <= q_r[i];
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - atan_turn(5'(i));
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + atan_turn(5'(i));
      end
    end
  end

  logic signed [XW-1:0] xr, yr;
  coef_t c, s;
  assign xr = (x_r[CORDIC_STEPS] + XW'(1 <<< (29-FRAC_BITS))) >>> (30-FRAC_BITS);
  assign yr = (y_r[CORDIC_STEPS] + XW'(1 <<< (29-FRAC_BITS))) >>> (30-FRAC_BITS);
  assign c = clamp_one((COEF_BITS+2)'(xr > XW'(ONE) ? XW'(ONE) : (xr < -XW'(ONE) ? -XW'(ONE) : xr)));
  assign s = clamp_one((COEF_BITS+2)'(yr > XW'(ONE) ? XW'(ONE) : (yr < -XW'(ONE) ? -XW'(ONE) : yr)));

  always_ff @(posedge clk) begin
    unique case (q_r[CORDIC_STEPS])
      2'd0: begin cos_o <= c;  sin_o <= s;  end
      2'd1: begin cos_o <= -s; sin_o <= c;  end
      2'd2: begin cos_o <= -c; sin_o <= -s; end
      default: begin cos_o <= s; sin_o <= -c; end
    endcase
  end
endmodule
`default_nettype wire
